// File: design/dtfp_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal text parser.
`default_nettype none
package dtfp_pkg;

	localparam int unsigned INT_W  = 32;
	localparam int unsigned FRAC_W = 32;
	localparam int unsigned ACC_W  = 30;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned KDIG_W = 4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac_part;
		logic [CNT_W-1:0]  consumed;
		logic              overflow;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic acc_en;    // fold a digit or point into the accumulators
		logic term_take; // snapshot the number, start the divide, clear accumulators
		logic out_load;  // move the finished result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_term;   // the offered character ends the number
		logic div_done;  // quotient is ready
	} sts_t;

	function automatic logic [ACC_W-1:0] pow10(input logic [KDIG_W-1:0] k);
		logic [ACC_W-1:0] p;
		case (k)
			4'd0: p = 30'd1;
			4'd1: p = 30'd10;
			4'd2: p = 30'd100;
			4'd3: p = 30'd1000;
			4'd4: p = 30'd10000;
			4'd5: p = 30'd100000;
			4'd6: p = 30'd1000000;
			4'd7: p = 30'd10000000;
			4'd8: p = 30'd100000000;
			4'd9: p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// File: design/dtfp_stream_if.sv
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface dtfp_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/dtfp_div.sv
// Restoring divider: fraction numerator shifted by 32, over a power of ten, one bit a cycle.
`default_nettype none
module dtfp_div
	import dtfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ACC_W-1:0]  numer,
	input  wire logic [ACC_W-1:0]  denom,
	output logic                   done,
	output logic [FRAC_W-1:0]      quot
);
	localparam int unsigned STEP_W = $clog2(FRAC_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  den_q;
	logic [FRAC_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [ACC_W:0]    rem2;
	logic [ACC_W+1:0]  diff;
	logic              fits;

	// numerator stays below the divisor, so twice the remainder fits ACC_W+1 bits
	assign rem2 = {rem_q, 1'b0};
	assign diff = {1'b0, rem2} - {2'b00, den_q};
	assign fits = ~diff[ACC_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer;
			den_q  <= denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[ACC_W-1:0] : rem2[ACC_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// File: design/dtfp_dp.sv
// Datapath: digit accumulators, result snapshot, divider and output register.
`default_nettype none
module dtfp_dp
	import dtfp_pkg::*;
#(
	parameter int unsigned FRAC_DIGITS = 9,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire char_t ch,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	output res_t       res
);
	logic [INT_W-1:0]      int_acc_q;
	logic [ACC_W-1:0]      frac_acc_q;
	logic [KDIG_W-1:0]     frac_digits_q;
	logic                  seen_point_q;
	logic [COUNT_BITS-1:0] char_count_q;
	logic                  sat_flag_q;

	logic [INT_W-1:0]      snap_int_q;
	logic [CNT_W-1:0]      snap_cnt_q;
	logic                  snap_ovf_q;
	res_t                  res_q;

	logic                  is_digit;
	logic                  is_point;
	logic [3:0]            dig;
	logic [INT_W+3:0]      int_next;
	logic [ACC_W-1:0]      frac_next;
	logic [31:0]           cnt_ext;
	logic [CNT_W-1:0]      cnt_sat;
	logic                  div_done;
	logic [FRAC_W-1:0]     quot;

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_point  = (ch == CH_POINT);
	assign dig       = 4'(ch - CH_ZERO);
	// times ten as two shifts and an add
	assign int_next  = ({4'b0, int_acc_q} << 3) + ({4'b0, int_acc_q} << 1)
		+ {{INT_W{1'b0}}, dig};
	assign frac_next = (frac_acc_q << 3) + (frac_acc_q << 1) + {{(ACC_W-4){1'b0}}, dig};
	assign cnt_ext   = 32'(char_count_q);
	assign cnt_sat   = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_acc_q     <= '0;
			frac_acc_q    <= '0;
			frac_digits_q <= '0;
			seen_point_q  <= 1'b0;
			char_count_q  <= '0;
			sat_flag_q    <= 1'b0;
		end else if (cmd.term_take) begin
			int_acc_q     <= '0;
			frac_acc_q    <= '0;
			frac_digits_q <= '0;
			seen_point_q  <= 1'b0;
			char_count_q  <= '0;
			sat_flag_q    <= 1'b0;
		end else if (cmd.acc_en) begin
			if (char_count_q != '1) begin
				char_count_q <= char_count_q + 1'b1;
			end
			if (is_digit) begin
				if (!seen_point_q) begin
					if (sat_flag_q || (int_next[INT_W+3:INT_W] != 4'b0)) begin
						int_acc_q  <= '1;
						sat_flag_q <= 1'b1;
					end else begin
						int_acc_q <= int_next[INT_W-1:0];
					end
				end else if (frac_digits_q < KDIG_W'(FRAC_DIGITS)) begin
					frac_acc_q    <= frac_next;
					frac_digits_q <= frac_digits_q + 1'b1;
				end
			end else if (is_point) begin
				seen_point_q <= 1'b1;
			end
		end
	end

	// snapshot and output registers are payload only
	always_ff @(posedge clk) begin
		if (cmd.term_take) begin
			snap_int_q <= int_acc_q;
			snap_cnt_q <= cnt_sat;
			snap_ovf_q <= sat_flag_q;
		end
		if (cmd.out_load) begin
			res_q.int_part  <= snap_int_q;
			res_q.frac_part <= quot;
			res_q.consumed  <= snap_cnt_q;
			res_q.overflow  <= snap_ovf_q;
		end
	end

	dtfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.term_take),
		.numer  (frac_acc_q),
		.denom  (pow10(frac_digits_q)),
		.done   (div_done),
		.quot   (quot)
	);

	assign sts.is_term  = ~(is_digit | is_point);
	assign sts.div_done = div_done;
	assign res          = res_q;
endmodule
`default_nettype wire

// File: design/dtfp_ctrl.sv
// Controller: accept, divide and hand-off sequencing plus output valid.
`default_nettype none
module dtfp_ctrl
	import dtfp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [2:0] {
		ST_ACC  = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   take;
	logic   out_free;

	assign in_ready = (state_q == ST_ACC);
	assign take     = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd.acc_en    = 1'b0;
		cmd.term_take = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_ACC: begin
				if (take) begin
					if (sts.is_term) begin
						cmd.term_take = 1'b1;
						state_d       = ST_DIV;
					end else begin
						cmd.acc_en = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_ACC;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: design/decimal_text_to_fixed_point_core.sv
// Top level: decimal character stream to 32.32 fixed point with consumed count.
//
//   channel  dir  payload                                    item
//   chars    in   data : 8-bit character                     one character
//   result   out  data : int_part, frac_part, consumed,      one parsed number
//                        overflow
//
// A digit or point is folded in as it is taken; chars.ready stays high until a
// terminator is taken, which starts a restoring divide of the fraction by 10^k. The next
// character is taken only once the quotient is loaded into the output register.
// The output register lets parsing of the next number run while a result waits.
// arst_n clears the controller and the accumulators at once; there is no clearing pass.
// A stalled result blocks input only when the next divide finishes first.
`default_nettype none
module decimal_text_to_fixed_point_core
	import dtfp_pkg::*;
#(
	parameter int unsigned FRAC_DIGITS = 9,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dtfp_stream_if.sink   chars,
	dtfp_stream_if.source result
);
	cmd_t  cmd;
	sts_t  sts;
	res_t  res;
	char_t ch;
	logic  in_ready;
	logic  out_valid;

	assign ch = chars.data;

	// sequencing: when to fold, when to divide, when to hand the result over
	dtfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// accumulators, divider and output register
	dtfp_dp #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (ch),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	assign chars.ready  = in_ready;
	assign result.valid = out_valid;
	assign result.data  = res;

	// a terminator stops intake for the divide
	a_term_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.term_take |=> !in_ready)
		else $error("input still ready after a terminator");

	// a loaded result is never dropped before it is taken
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result.ready |=> out_valid && $stable(res))
		else $error("pending result lost or changed");

	// load only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || result.ready))
		else $error("result loaded over a pending one");

	// fold, terminate and load are exclusive commands
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc_en, cmd.term_take, cmd.out_load}))
		else $error("conflicting datapath commands");
endmodule
`default_nettype wire
